@@ sv/dvrt_pkg.sv @@
// Shared types, constants and helpers for the distance-vector route table.
package dvrt_pkg;

   localparam int NEIGHBOR_SLOTS  = 8;
   localparam int ROUTE_SLOTS     = 32;
   localparam int TIMEOUT_PERIODS = 4;

   localparam int ADDR_W   = 32;
   localparam int COST_W   = 16;
   localparam int STAMP_W  = 16;
   localparam int SIL_W    = 20;
   localparam int PERIOD_W = 16;
   localparam int LIMIT_W  = PERIOD_W + $clog2(TIMEOUT_PERIODS);
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int GONE_W   = 4;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam int NB_IDX_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
   localparam int NB_CNT_W = $clog2(NEIGHBOR_SLOTS + 1);
   localparam int RT_IDX_W = $clog2(ROUTE_SLOTS);
   localparam int RT_CNT_W = $clog2(ROUTE_SLOTS + 1);

   localparam logic [RT_CNT_W-1:0] RT_FULL_CNT = RT_CNT_W'(ROUTE_SLOTS);
   localparam logic [RT_IDX_W-1:0] RT_LAST_IDX = RT_IDX_W'(ROUTE_SLOTS - 1);
   localparam logic [NB_CNT_W-1:0] NB_FULL_CNT = NB_CNT_W'(NEIGHBOR_SLOTS);
   localparam logic [SIL_W-1:0]    SIL_MAX     = '1;
   localparam logic [GONE_W-1:0]   GONE_MAX    = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 3'd0,
      OP_DEL    = 3'd1,
      OP_UPDATE = 3'd2,
      OP_LOOKUP = 3'd3,
      OP_TICK   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE = 2'd0,
      STS_MISS = 2'd1,
      STS_FULL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ADDRESS   = 1'b0,
      CSR_UPDATE_PERIOD = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      RE_APPEND,
      RE_UPSERT,
      RE_DROP_LINK,
      RE_DROP_STALE,
      RE_LOOKUP
   } re_kind_type;

   typedef enum logic [1:0] {
      RE_IDLE,
      RE_SCAN,
      RE_DONE
   } re_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GO,
      S_WAIT,
      S_TICK_CHK,
      S_RESP
   } seq_state_type;

   typedef enum logic [2:0] {
      PH_ADD,
      PH_DEL,
      PH_UPD_ADD,
      PH_UPD_MATCH,
      PH_UPD_PURGE,
      PH_LOOKUP,
      PH_TICK
   } phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  via;
      logic [COST_W-1:0]  metric;
      logic [STAMP_W-1:0] stamp;
   } rt_entry_type;

   typedef struct packed {
      logic               start;
      re_kind_type        kind;
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  via;
      logic [COST_W-1:0]  cost;
      logic [STAMP_W-1:0] stamp;
   } re_cmd_type;

   typedef struct packed {
      logic                done;
      logic                full;
      logic                found;
      logic [ADDR_W-1:0]   via;
      logic [COST_W-1:0]   cost;
      logic [RT_CNT_W-1:0] count;
   } re_rsp_type;

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
   endfunction

endpackage

@@ sv/dvrt_if.sv @@
// Request and response channel interfaces of the route table.
interface dvrt_req_if;
   logic                           valid;
   logic                           ready;
   logic [dvrt_pkg::OP_W-1:0]      op;
   logic [dvrt_pkg::ADDR_W-1:0]    neighbor_addr;
   logic [dvrt_pkg::ADDR_W-1:0]    dest_addr;
   logic [dvrt_pkg::COST_W-1:0]    metric;
   logic [dvrt_pkg::COST_W-1:0]    link_cost;
   logic                           last_entry;

   modport source (output valid, op, neighbor_addr, dest_addr, metric, link_cost,
                   last_entry, input ready);
   modport sink   (input valid, op, neighbor_addr, dest_addr, metric, link_cost,
                   last_entry, output ready);
endinterface

interface dvrt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dvrt_pkg::STATUS_W-1:0]  status;
   logic [dvrt_pkg::ADDR_W-1:0]    next_hop;
   logic [dvrt_pkg::COST_W-1:0]    route_cost;
   logic [dvrt_pkg::GONE_W-1:0]    timed_out;

   modport source (output valid, status, next_hop, route_cost, timed_out, input ready);
   modport sink   (input valid, status, next_hop, route_cost, timed_out, output ready);
endinterface

@@ sv/dvrt_route_engine.sv @@
// Route table memory with its scan, compaction, upsert and lookup engine.
module dvrt_route_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  dvrt_pkg::re_cmd_type cmd,
   output dvrt_pkg::re_rsp_type rsp
);

   dvrt_pkg::rt_entry_type mem [dvrt_pkg::ROUTE_SLOTS];

   dvrt_pkg::re_state_type state_ff, state_in;
   dvrt_pkg::re_cmd_type   key_ff, key_in;
   dvrt_pkg::rt_entry_type rdata_ff;
   logic [dvrt_pkg::RT_CNT_W-1:0] count_ff, count_in;
   logic [dvrt_pkg::RT_CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dvrt_pkg::RT_CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dvrt_pkg::RT_IDX_W-1:0] pidx_ff, pidx_in;
   logic [dvrt_pkg::RT_IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic                          pv_ff, pv_in;
   logic                          hit_ff, hit_in;
   logic                          full_ff, full_in;
   logic                          found_ff, found_in;
   logic [dvrt_pkg::ADDR_W-1:0]   best_via_ff, best_via_in;
   logic [dvrt_pkg::COST_W-1:0]   best_cost_ff, best_cost_in;

   logic                          issue_c, scan_end_c, cnt_full_c, keep_c, match_c;
   logic [dvrt_pkg::RT_IDX_W-1:0] tail_c;
   logic                          we_c;
   logic [dvrt_pkg::RT_IDX_W-1:0] waddr_c;
   dvrt_pkg::rt_entry_type        wdata_c;

   assign issue_c    = (state_ff == dvrt_pkg::RE_SCAN) && (rd_ptr_ff < count_ff);
   assign scan_end_c = (state_ff == dvrt_pkg::RE_SCAN) && !issue_c && !pv_ff;
   assign cnt_full_c = (count_ff >= dvrt_pkg::RT_FULL_CNT);
   // append at the tail, or overwrite the last slot when full
   assign tail_c     = cnt_full_c ? dvrt_pkg::RT_LAST_IDX
                                  : count_ff[dvrt_pkg::RT_IDX_W-1:0];
   assign match_c    = (rdata_ff.dest == key_ff.dest) && (rdata_ff.via == key_ff.via);

   always_comb begin
      keep_c = 1'b1;
      case (key_ff.kind) inside
         dvrt_pkg::RE_DROP_LINK:
            keep_c = !((rdata_ff.via == key_ff.via) || (rdata_ff.dest == key_ff.via));
         dvrt_pkg::RE_DROP_STALE:
            keep_c = !((rdata_ff.via == key_ff.via) && (rdata_ff.dest != key_ff.via) &&
                       (rdata_ff.stamp != key_ff.stamp));
         default: keep_c = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvrt_pkg::RE_IDLE: begin
            if (cmd.start) begin
               state_in = (cmd.kind == dvrt_pkg::RE_APPEND) ? dvrt_pkg::RE_DONE
                                                            : dvrt_pkg::RE_SCAN;
            end
         end
         dvrt_pkg::RE_SCAN: begin
            if (scan_end_c) begin
               state_in = dvrt_pkg::RE_DONE;
            end
         end
         dvrt_pkg::RE_DONE: state_in = dvrt_pkg::RE_IDLE;
         default:           state_in = dvrt_pkg::RE_IDLE;
      endcase
   end

   always_comb begin
      key_in       = key_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      pidx_in      = pidx_ff;
      pv_in        = 1'b0;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      full_in      = full_ff;
      found_in     = found_ff;
      best_via_in  = best_via_ff;
      best_cost_in = best_cost_ff;
      we_c         = 1'b0;
      waddr_c      = tail_c;
      wdata_c      = '{dest: key_ff.dest, via: key_ff.via, metric: key_ff.cost,
                       stamp: key_ff.stamp};
      if (state_ff == dvrt_pkg::RE_IDLE && cmd.start) begin
         key_in    = cmd;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         hit_in    = 1'b0;
         found_in  = 1'b0;
         full_in   = 1'b0;
         if (cmd.kind == dvrt_pkg::RE_APPEND) begin
            we_c    = 1'b1;
            wdata_c = '{dest: cmd.dest, via: cmd.via, metric: cmd.cost, stamp: cmd.stamp};
            full_in = cnt_full_c;
            if (!cnt_full_c) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
      if (issue_c) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         pv_in     = 1'b1;
         pidx_in   = rd_ptr_ff[dvrt_pkg::RT_IDX_W-1:0];
      end
      if (pv_ff) begin
         case (key_ff.kind) inside
            dvrt_pkg::RE_UPSERT: begin
               if (match_c && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pidx_ff;
               end
            end
            dvrt_pkg::RE_LOOKUP: begin
               if ((rdata_ff.dest == key_ff.dest) &&
                   (!found_ff || (rdata_ff.metric < best_cost_ff))) begin
                  found_in     = 1'b1;
                  best_via_in  = rdata_ff.via;
                  best_cost_in = rdata_ff.metric;
               end
            end
            dvrt_pkg::RE_DROP_LINK, dvrt_pkg::RE_DROP_STALE: begin
               // compact: survivors slide down to the write pointer
               if (keep_c) begin
                  we_c      = 1'b1;
                  waddr_c   = wr_ptr_ff[dvrt_pkg::RT_IDX_W-1:0];
                  wdata_c   = rdata_ff;
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (scan_end_c) begin
         case (key_ff.kind) inside
            dvrt_pkg::RE_DROP_LINK, dvrt_pkg::RE_DROP_STALE: count_in = wr_ptr_ff;
            dvrt_pkg::RE_UPSERT: begin
               we_c = 1'b1;
               if (hit_ff) begin
                  waddr_c = hit_idx_ff;
               end else begin
                  full_in = cnt_full_c;
                  if (!cnt_full_c) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dvrt_pkg::RE_IDLE;
         count_ff <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pv_ff    <= pv_in;
      end
      key_ff       <= key_in;
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      pidx_ff      <= pidx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      full_ff      <= full_in;
      found_ff     <= found_in;
      best_via_ff  <= best_via_in;
      best_cost_ff <= best_cost_in;
   end

   always_ff @(posedge clock) begin
      if (we_c) begin
         mem[waddr_c] <= wdata_c;
      end
      if (issue_c) begin
         rdata_ff <= mem[rd_ptr_ff[dvrt_pkg::RT_IDX_W-1:0]];
      end
   end

   assign rsp.done  = (state_ff == dvrt_pkg::RE_DONE);
   assign rsp.full  = full_ff;
   assign rsp.found = found_ff;
   assign rsp.via   = best_via_ff;
   assign rsp.cost  = best_cost_ff;
   assign rsp.count = count_ff;

endmodule

@@ sv/distance_vector_route_table_unit.sv @@
// Sequencing: add and update append without a scan; delete, update, lookup scan the
// route table at one entry per cycle through the memory read port, an update with
// last_entry makes up to two passes, a tick one pass per timed-out neighbor.
// One item at a time; the next item is taken once the result is queued.
// Reset: synchronous, active high; clears counts, message sequence and handshake state.
// Table contents are not cleared; only entries below the counts are ever read.
module distance_vector_route_table_unit (
   input  logic                           clock,
   input  logic                           reset,
   dvrt_req_if.sink                       req_chan,
   dvrt_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [dvrt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dvrt_pkg::CSR_W-1:0]     csr_write_data
);

   // configuration
   logic [dvrt_pkg::ADDR_W-1:0]   own_addr_ff;
   logic [dvrt_pkg::PERIOD_W-1:0] period_ff;

   // neighbor table, small enough for flops with a parallel search
   logic [dvrt_pkg::ADDR_W-1:0] nb_addr_ff [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::ADDR_W-1:0] nb_addr_in [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::COST_W-1:0] nb_wt_ff   [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::COST_W-1:0] nb_wt_in   [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::SIL_W-1:0]  nb_sil_ff  [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::SIL_W-1:0]  nb_sil_in  [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::NB_CNT_W-1:0] nb_cnt_ff, nb_cnt_in;

   // sequencer state and the item being worked on
   dvrt_pkg::seq_state_type state_ff, state_in;
   dvrt_pkg::phase_type     phase_ff, phase_in;
   dvrt_pkg::re_kind_type   cmd_kind_ff, cmd_kind_in;
   logic [dvrt_pkg::ADDR_W-1:0]  cmd_dest_ff, cmd_dest_in;
   logic [dvrt_pkg::ADDR_W-1:0]  cmd_via_ff, cmd_via_in;
   logic [dvrt_pkg::COST_W-1:0]  cmd_cost_ff, cmd_cost_in;
   logic [dvrt_pkg::ADDR_W-1:0]  snd_ff, snd_in;
   logic [dvrt_pkg::ADDR_W-1:0]  dst_ff, dst_in;
   logic [dvrt_pkg::COST_W-1:0]  ucost_ff, ucost_in;
   logic                         last_ff, last_in;
   logic [dvrt_pkg::STAMP_W-1:0] seq_ff, seq_in;

   // pending result
   dvrt_pkg::status_type         res_status_ff, res_status_in;
   logic [dvrt_pkg::ADDR_W-1:0]  res_hop_ff, res_hop_in;
   logic [dvrt_pkg::COST_W-1:0]  res_cost_ff, res_cost_in;
   logic [dvrt_pkg::GONE_W-1:0]  res_gone_ff, res_gone_in;

   // output register
   logic                          rsp_valid_ff;
   logic [dvrt_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [dvrt_pkg::ADDR_W-1:0]   rsp_hop_ff;
   logic [dvrt_pkg::COST_W-1:0]   rsp_cost_ff;
   logic [dvrt_pkg::GONE_W-1:0]   rsp_gone_ff;

   dvrt_pkg::re_cmd_type eng_cmd;
   dvrt_pkg::re_rsp_type eng_rsp;

   logic                          accept_c, rsp_load_c;
   logic                          nb_found_c, nb_full_c, addable_c, to_any_c;
   logic [dvrt_pkg::NB_IDX_W-1:0] nb_idx_c, to_idx_c, rm_idx_c;
   logic                          rm_c;
   logic [dvrt_pkg::COST_W-1:0]   weight_c;
   logic [dvrt_pkg::LIMIT_W-1:0]  limit_c;
   logic                          go_c, chk_c, resp_c;
   dvrt_pkg::op_type              op_c;

   assign req_chan.ready = (state_ff == dvrt_pkg::S_IDLE);
   assign accept_c       = req_chan.valid && req_chan.ready;
   assign rsp_load_c     = (state_ff == dvrt_pkg::S_RESP) && (!rsp_valid_ff || rsp_chan.ready);
   assign op_c           = dvrt_pkg::op_type'(req_chan.op);
   assign limit_c        = dvrt_pkg::LIMIT_W'(period_ff) *
                           dvrt_pkg::LIMIT_W'(dvrt_pkg::TIMEOUT_PERIODS);
   assign nb_full_c      = (nb_cnt_ff >= dvrt_pkg::NB_FULL_CNT);
   assign addable_c      = !nb_full_c && (req_chan.neighbor_addr != own_addr_ff);
   assign weight_c       = nb_found_c ? nb_wt_ff[nb_idx_c] : req_chan.link_cost;

   // neighbor search on the incoming address, and timeout search for ticks;
   // lowest slot wins in both
   always_comb begin
      nb_found_c = 1'b0;
      nb_idx_c   = '0;
      to_any_c   = 1'b0;
      to_idx_c   = '0;
      for (int i = dvrt_pkg::NEIGHBOR_SLOTS - 1; i >= 0; i--) begin
         if ((dvrt_pkg::NB_CNT_W'(i) < nb_cnt_ff) &&
             (nb_addr_ff[i] == req_chan.neighbor_addr)) begin
            nb_found_c = 1'b1;
            nb_idx_c   = dvrt_pkg::NB_IDX_W'(i);
         end
         if ((dvrt_pkg::NB_CNT_W'(i) < nb_cnt_ff) &&
             (nb_sil_ff[i] > dvrt_pkg::SIL_W'(limit_c))) begin
            to_any_c = 1'b1;
            to_idx_c = dvrt_pkg::NB_IDX_W'(i);
         end
      end
   end

   // neighbor table updates: add at the tail, remove with shift-down, age, refresh
   always_comb begin
      nb_cnt_in = nb_cnt_ff;
      rm_c      = 1'b0;
      rm_idx_c  = nb_idx_c;
      for (int i = 0; i < dvrt_pkg::NEIGHBOR_SLOTS; i++) begin
         nb_addr_in[i] = nb_addr_ff[i];
         nb_wt_in[i]   = nb_wt_ff[i];
         nb_sil_in[i]  = nb_sil_ff[i];
      end
      if (accept_c) begin
         unique case (op_c)
            dvrt_pkg::OP_ADD: begin
               if (!nb_found_c && addable_c) begin
                  nb_addr_in[nb_cnt_ff[dvrt_pkg::NB_IDX_W-1:0]] = req_chan.neighbor_addr;
                  nb_wt_in[nb_cnt_ff[dvrt_pkg::NB_IDX_W-1:0]]   = req_chan.metric;
                  nb_sil_in[nb_cnt_ff[dvrt_pkg::NB_IDX_W-1:0]]  = '0;
                  nb_cnt_in = nb_cnt_ff + 1'b1;
               end
            end
            dvrt_pkg::OP_DEL: rm_c = nb_found_c;
            dvrt_pkg::OP_UPDATE: begin
               if (nb_found_c) begin
                  nb_sil_in[nb_idx_c] = '0;
               end else if (addable_c) begin
                  nb_addr_in[nb_cnt_ff[dvrt_pkg::NB_IDX_W-1:0]] = req_chan.neighbor_addr;
                  nb_wt_in[nb_cnt_ff[dvrt_pkg::NB_IDX_W-1:0]]   = req_chan.link_cost;
                  nb_sil_in[nb_cnt_ff[dvrt_pkg::NB_IDX_W-1:0]]  = '0;
                  nb_cnt_in = nb_cnt_ff + 1'b1;
               end
            end
            dvrt_pkg::OP_TICK: begin
               for (int i = 0; i < dvrt_pkg::NEIGHBOR_SLOTS; i++) begin
                  if (nb_sil_ff[i] != dvrt_pkg::SIL_MAX) begin
                     nb_sil_in[i] = nb_sil_ff[i] + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      if (state_ff == dvrt_pkg::S_TICK_CHK && to_any_c) begin
         rm_c     = 1'b1;
         rm_idx_c = to_idx_c;
      end
      if (rm_c) begin
         for (int i = 0; i < dvrt_pkg::NEIGHBOR_SLOTS - 1; i++) begin
            if (dvrt_pkg::NB_IDX_W'(i) >= rm_idx_c) begin
               nb_addr_in[i] = nb_addr_ff[i+1];
               nb_wt_in[i]   = nb_wt_ff[i+1];
               nb_sil_in[i]  = nb_sil_ff[i+1];
            end
         end
         nb_cnt_in = nb_cnt_ff - 1'b1;
      end
   end

   // sequencing decisions and datapath next values
   always_comb begin
      go_c          = 1'b0;
      chk_c         = 1'b0;
      resp_c        = 1'b0;
      phase_in      = phase_ff;
      cmd_kind_in   = cmd_kind_ff;
      cmd_dest_in   = cmd_dest_ff;
      cmd_via_in    = cmd_via_ff;
      cmd_cost_in   = cmd_cost_ff;
      snd_in        = snd_ff;
      dst_in        = dst_ff;
      ucost_in      = ucost_ff;
      last_in       = last_ff;
      seq_in        = seq_ff;
      res_status_in = res_status_ff;
      res_hop_in    = res_hop_ff;
      res_cost_in   = res_cost_ff;
      res_gone_in   = res_gone_ff;
      unique case (state_ff)
         dvrt_pkg::S_IDLE: begin
            if (accept_c) begin
               res_status_in = dvrt_pkg::STS_MISS;
               res_hop_in    = '0;
               res_cost_in   = '0;
               res_gone_in   = '0;
               snd_in        = req_chan.neighbor_addr;
               dst_in        = req_chan.dest_addr;
               last_in       = req_chan.last_entry;
               ucost_in      = dvrt_pkg::sat_add(weight_c, req_chan.metric);
               unique case (op_c)
                  dvrt_pkg::OP_ADD: begin
                     if (!nb_found_c && addable_c) begin
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_ADD;
                        cmd_kind_in = dvrt_pkg::RE_APPEND;
                        cmd_dest_in = req_chan.neighbor_addr;
                        cmd_via_in  = req_chan.neighbor_addr;
                        cmd_cost_in = req_chan.metric;
                     end else begin
                        resp_c = 1'b1;
                     end
                  end
                  dvrt_pkg::OP_DEL: begin
                     if (nb_found_c) begin
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_DEL;
                        cmd_kind_in = dvrt_pkg::RE_DROP_LINK;
                        cmd_via_in  = req_chan.neighbor_addr;
                     end else begin
                        resp_c = 1'b1;
                     end
                  end
                  dvrt_pkg::OP_UPDATE: begin
                     res_status_in = dvrt_pkg::STS_DONE;
                     if (!nb_found_c && addable_c) begin
                        // unknown sender joins first, with its own direct route
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_UPD_ADD;
                        cmd_kind_in = dvrt_pkg::RE_APPEND;
                        cmd_dest_in = req_chan.neighbor_addr;
                        cmd_via_in  = req_chan.neighbor_addr;
                        cmd_cost_in = req_chan.link_cost;
                     end else if (req_chan.dest_addr != req_chan.neighbor_addr) begin
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_UPD_MATCH;
                        cmd_kind_in = dvrt_pkg::RE_UPSERT;
                        cmd_dest_in = req_chan.dest_addr;
                        cmd_via_in  = req_chan.neighbor_addr;
                        cmd_cost_in = dvrt_pkg::sat_add(weight_c, req_chan.metric);
                     end else if (req_chan.last_entry) begin
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_UPD_PURGE;
                        cmd_kind_in = dvrt_pkg::RE_DROP_STALE;
                        cmd_via_in  = req_chan.neighbor_addr;
                     end else begin
                        resp_c = 1'b1;
                     end
                  end
                  dvrt_pkg::OP_LOOKUP: begin
                     go_c        = 1'b1;
                     phase_in    = dvrt_pkg::PH_LOOKUP;
                     cmd_kind_in = dvrt_pkg::RE_LOOKUP;
                     cmd_dest_in = req_chan.dest_addr;
                  end
                  dvrt_pkg::OP_TICK: begin
                     res_status_in = dvrt_pkg::STS_DONE;
                     chk_c         = 1'b1;
                  end
                  default: resp_c = 1'b1;
               endcase
            end
         end
         dvrt_pkg::S_GO: ;
         dvrt_pkg::S_WAIT: begin
            if (eng_rsp.done) begin
               unique case (phase_ff)
                  dvrt_pkg::PH_ADD: begin
                     res_status_in = eng_rsp.full ? dvrt_pkg::STS_FULL : dvrt_pkg::STS_DONE;
                     resp_c        = 1'b1;
                  end
                  dvrt_pkg::PH_DEL: begin
                     res_status_in = dvrt_pkg::STS_DONE;
                     resp_c        = 1'b1;
                  end
                  dvrt_pkg::PH_UPD_ADD: begin
                     if (dst_ff != snd_ff) begin
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_UPD_MATCH;
                        cmd_kind_in = dvrt_pkg::RE_UPSERT;
                        cmd_dest_in = dst_ff;
                        cmd_via_in  = snd_ff;
                        cmd_cost_in = ucost_ff;
                     end else if (last_ff) begin
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_UPD_PURGE;
                        cmd_kind_in = dvrt_pkg::RE_DROP_STALE;
                        cmd_via_in  = snd_ff;
                     end else begin
                        resp_c = 1'b1;
                     end
                  end
                  dvrt_pkg::PH_UPD_MATCH: begin
                     res_status_in = eng_rsp.full ? dvrt_pkg::STS_FULL : dvrt_pkg::STS_DONE;
                     if (last_ff) begin
                        go_c        = 1'b1;
                        phase_in    = dvrt_pkg::PH_UPD_PURGE;
                        cmd_kind_in = dvrt_pkg::RE_DROP_STALE;
                        cmd_via_in  = snd_ff;
                     end else begin
                        resp_c = 1'b1;
                     end
                  end
                  dvrt_pkg::PH_UPD_PURGE: begin
                     // message closed: advance the sequence, wrapping
                     seq_in = seq_ff + 1'b1;
                     resp_c = 1'b1;
                  end
                  dvrt_pkg::PH_LOOKUP: begin
                     res_status_in = eng_rsp.found ? dvrt_pkg::STS_DONE : dvrt_pkg::STS_MISS;
                     res_hop_in    = eng_rsp.found ? eng_rsp.via : '0;
                     res_cost_in   = eng_rsp.found ? eng_rsp.cost : '0;
                     resp_c        = 1'b1;
                  end
                  dvrt_pkg::PH_TICK: chk_c = 1'b1;
                  default: resp_c = 1'b1;
               endcase
            end
         end
         dvrt_pkg::S_TICK_CHK: begin
            // drop one timed-out neighbor per pass, then purge its routes
            if (to_any_c) begin
               go_c        = 1'b1;
               phase_in    = dvrt_pkg::PH_TICK;
               cmd_kind_in = dvrt_pkg::RE_DROP_LINK;
               cmd_via_in  = nb_addr_ff[to_idx_c];
               if (res_gone_ff != dvrt_pkg::GONE_MAX) begin
                  res_gone_in = res_gone_ff + 1'b1;
               end
            end else begin
               resp_c = 1'b1;
            end
         end
         dvrt_pkg::S_RESP: ;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvrt_pkg::S_IDLE, dvrt_pkg::S_WAIT, dvrt_pkg::S_TICK_CHK: begin
            if (go_c) begin
               state_in = dvrt_pkg::S_GO;
            end else if (chk_c) begin
               state_in = dvrt_pkg::S_TICK_CHK;
            end else if (resp_c) begin
               state_in = dvrt_pkg::S_RESP;
            end
         end
         dvrt_pkg::S_GO: state_in = dvrt_pkg::S_WAIT;
         dvrt_pkg::S_RESP: begin
            if (rsp_load_c) begin
               state_in = dvrt_pkg::S_IDLE;
            end
         end
         default: state_in = dvrt_pkg::S_IDLE;
      endcase
   end

   assign eng_cmd.start = (state_ff == dvrt_pkg::S_GO);
   assign eng_cmd.kind  = cmd_kind_ff;
   assign eng_cmd.dest  = cmd_dest_ff;
   assign eng_cmd.via   = cmd_via_ff;
   assign eng_cmd.cost  = cmd_cost_ff;
   assign eng_cmd.stamp = seq_ff;

   dvrt_route_engine u_route_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (eng_cmd),
      .rsp   (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvrt_pkg::S_IDLE;
         nb_cnt_ff    <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         own_addr_ff  <= '0;
         period_ff    <= dvrt_pkg::PERIOD_W'(5);
      end else begin
         state_ff  <= state_in;
         nb_cnt_ff <= nb_cnt_in;
         seq_ff    <= seq_in;
         if (rsp_load_c) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (dvrt_pkg::csr_index_type'(csr_index))
               dvrt_pkg::CSR_OWN_ADDRESS:   own_addr_ff <= csr_write_data;
               dvrt_pkg::CSR_UPDATE_PERIOD:
                  period_ff <= csr_write_data[dvrt_pkg::PERIOD_W-1:0];
               default: ;
            endcase
         end
      end
      for (int i = 0; i < dvrt_pkg::NEIGHBOR_SLOTS; i++) begin
         nb_addr_ff[i] <= nb_addr_in[i];
         nb_wt_ff[i]   <= nb_wt_in[i];
         nb_sil_ff[i]  <= nb_sil_in[i];
      end
      phase_ff      <= phase_in;
      cmd_kind_ff   <= cmd_kind_in;
      cmd_dest_ff   <= cmd_dest_in;
      cmd_via_ff    <= cmd_via_in;
      cmd_cost_ff   <= cmd_cost_in;
      snd_ff        <= snd_in;
      dst_ff        <= dst_in;
      ucost_ff      <= ucost_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_hop_ff    <= res_hop_in;
      res_cost_ff   <= res_cost_in;
      res_gone_ff   <= res_gone_in;
      if (rsp_load_c) begin
         rsp_status_ff <= res_status_ff;
         rsp_hop_ff    <= res_hop_ff;
         rsp_cost_ff   <= res_cost_ff;
         rsp_gone_ff   <= res_gone_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.next_hop   = rsp_hop_ff;
   assign rsp_chan.route_cost = rsp_cost_ff;
   assign rsp_chan.timed_out  = rsp_gone_ff;

`ifndef SYNTHESIS
   a_route_count: assert property (@(posedge clock) disable iff (reset)
      eng_rsp.count <= dvrt_pkg::RT_FULL_CNT)
      else $error("route count beyond table size");
   a_nb_count: assert property (@(posedge clock) disable iff (reset)
      nb_cnt_ff <= dvrt_pkg::NB_FULL_CNT)
      else $error("neighbor count beyond table size");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      eng_rsp.done |-> (state_ff == dvrt_pkg::S_WAIT))
      else $error("route engine finished without a waiting sequencer");
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dvrt_pkg::S_RESP))
      else $error("result raised outside the response step");
`endif

endmodule

@@ sim/distance_vector_route_table_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the distance-vector route table unit.
module distance_vector_route_table_unit_test;

   // Opcodes past the last defined operation; the block must answer each with a miss.
   localparam logic [dvrt_pkg::OP_W-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [dvrt_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [dvrt_pkg::OP_W-1:0] OP_UNUSED_HI  = 3'd7;
   localparam longint CYCLE_LIMIT = 3000000;
   // Cycles to let pass after the last result before touching the registers or ending.
   localparam int SETTLE_CYCLES = 400;

   typedef struct {
      logic [dvrt_pkg::OP_W-1:0]   op;
      logic [dvrt_pkg::ADDR_W-1:0] nbr;
      logic [dvrt_pkg::ADDR_W-1:0] dest;
      logic [dvrt_pkg::COST_W-1:0] metric;
      logic [dvrt_pkg::COST_W-1:0] link;
      logic                        last;
   } route_req_type;

   typedef struct {
      logic [dvrt_pkg::STATUS_W-1:0] status;
      logic [dvrt_pkg::ADDR_W-1:0]   hop;
      logic [dvrt_pkg::COST_W-1:0]   cost;
      logic [dvrt_pkg::GONE_W-1:0]   gone;
   } route_rsp_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [dvrt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dvrt_pkg::CSR_W-1:0] csr_write_data;

   dvrt_req_if req_chan ();
   dvrt_rsp_if rsp_chan ();

   distance_vector_route_table_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Items waiting to be offered, and results the table owes us.
   route_req_type pending_reqs[$];
   route_rsp_type owed_rsps[$];

   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_requests;       // bumped by the sequencer to ask for a long receiver hold-off
   int  hold_seen;
   int  hold_left;
   int  fail_count;
   int  items_sent;
   int  rsps_checked;
   int  timeouts_seen;
   int  full_seen;
   longint cycle_count = 0;

   // Shadow copy of the table state.
   logic [dvrt_pkg::ADDR_W-1:0]   nb_addr  [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::COST_W-1:0]   nb_wt    [dvrt_pkg::NEIGHBOR_SLOTS];
   logic [dvrt_pkg::SIL_W-1:0]    nb_sil   [dvrt_pkg::NEIGHBOR_SLOTS];
   int                            nb_cnt;
   logic [dvrt_pkg::ADDR_W-1:0]   rt_dest  [dvrt_pkg::ROUTE_SLOTS];
   logic [dvrt_pkg::ADDR_W-1:0]   rt_via   [dvrt_pkg::ROUTE_SLOTS];
   logic [dvrt_pkg::COST_W-1:0]   rt_cost  [dvrt_pkg::ROUTE_SLOTS];
   logic [dvrt_pkg::STAMP_W-1:0]  rt_stamp [dvrt_pkg::ROUTE_SLOTS];
   int                            rt_cnt;
   logic [dvrt_pkg::STAMP_W-1:0]  msg_seq;
   logic [dvrt_pkg::ADDR_W-1:0]   own_addr;
   logic [dvrt_pkg::PERIOD_W-1:0] period;

   // Address pool: small on purpose so that adds, deletes and lookups hit.
   logic [dvrt_pkg::ADDR_W-1:0] addr_pool [16];

   function automatic int nb_position(logic [dvrt_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < nb_cnt; i++)
         if (nb_addr[i] == a) return i;
      return -1;
   endfunction

   function automatic void drop_route_at(int k);
      for (int j = k; j + 1 < rt_cnt; j++) begin
         rt_dest[j]  = rt_dest[j+1];
         rt_via[j]   = rt_via[j+1];
         rt_cost[j]  = rt_cost[j+1];
         rt_stamp[j] = rt_stamp[j+1];
      end
      rt_cnt--;
   endfunction

   // Append a route; once the table is full the last slot gets overwritten.
   function automatic logic [dvrt_pkg::STATUS_W-1:0] append_route(
         logic [dvrt_pkg::ADDR_W-1:0] d, logic [dvrt_pkg::ADDR_W-1:0] v,
         logic [dvrt_pkg::COST_W-1:0] c);
      int k;
      logic [dvrt_pkg::STATUS_W-1:0] st;
      k = rt_cnt;
      st = dvrt_pkg::STS_DONE;
      if (k >= dvrt_pkg::ROUTE_SLOTS) begin
         k = dvrt_pkg::ROUTE_SLOTS - 1;
         st = dvrt_pkg::STS_FULL;
      end else begin
         rt_cnt++;
      end
      rt_dest[k] = d;
      rt_via[k] = v;
      rt_cost[k] = c;
      rt_stamp[k] = msg_seq;
      return st;
   endfunction

   function automatic logic [dvrt_pkg::STATUS_W-1:0] nb_adopt(
         logic [dvrt_pkg::ADDR_W-1:0] a, logic [dvrt_pkg::COST_W-1:0] w);
      if (nb_position(a) >= 0 || nb_cnt >= dvrt_pkg::NEIGHBOR_SLOTS || a == own_addr)
         return dvrt_pkg::STS_MISS;
      nb_addr[nb_cnt] = a;
      nb_wt[nb_cnt] = w;
      nb_sil[nb_cnt] = '0;
      nb_cnt++;
      return append_route(a, a, w);
   endfunction

   // Remove a neighbor and every route through it or to it.
   function automatic void drop_neighbor_at(int idx);
      logic [dvrt_pkg::ADDR_W-1:0] a;
      int i;
      a = nb_addr[idx];
      for (i = idx; i + 1 < nb_cnt; i++) begin
         nb_addr[i] = nb_addr[i+1];
         nb_wt[i] = nb_wt[i+1];
         nb_sil[i] = nb_sil[i+1];
      end
      nb_cnt--;
      i = 0;
      while (i < rt_cnt) begin
         if (rt_via[i] == a || rt_dest[i] == a) drop_route_at(i);
         else i++;
      end
   endfunction

   function automatic logic [dvrt_pkg::STATUS_W-1:0] apply_update(route_req_type r);
      logic [dvrt_pkg::COST_W-1:0] w;
      logic [dvrt_pkg::COST_W:0] sum;
      logic [dvrt_pkg::STATUS_W-1:0] st;
      int ni, i;
      st = dvrt_pkg::STS_DONE;
      ni = nb_position(r.nbr);
      if (ni < 0) begin
         // Unknown sender: try to adopt it, but use its link cost regardless.
         void'(nb_adopt(r.nbr, r.link));
         w = r.link;
      end else begin
         w = nb_wt[ni];
         nb_sil[ni] = '0;
      end
      if (r.dest != r.nbr) begin
         sum = {1'b0, w} + {1'b0, r.metric};
         if (sum[dvrt_pkg::COST_W]) sum = {1'b0, {dvrt_pkg::COST_W{1'b1}}};
         for (i = 0; i < rt_cnt; i++)
            if (rt_dest[i] == r.dest && rt_via[i] == r.nbr) break;
         if (i < rt_cnt) begin
            rt_cost[i] = sum[dvrt_pkg::COST_W-1:0];
            rt_stamp[i] = msg_seq;
         end else begin
            st = append_route(r.dest, r.nbr, sum[dvrt_pkg::COST_W-1:0]);
         end
      end
      if (r.last) begin
         // Purge routes through the sender that this message did not refresh.
         i = 0;
         while (i < rt_cnt) begin
            if (rt_via[i] == r.nbr && rt_dest[i] != r.nbr && rt_stamp[i] != msg_seq)
               drop_route_at(i);
            else
               i++;
         end
         msg_seq++;
      end
      return st;
   endfunction

   function automatic logic [dvrt_pkg::GONE_W-1:0] age_neighbors();
      logic [dvrt_pkg::LIMIT_W-1:0] lim;
      logic [dvrt_pkg::GONE_W-1:0] gone;
      int i;
      lim = dvrt_pkg::LIMIT_W'(period) * dvrt_pkg::LIMIT_W'(dvrt_pkg::TIMEOUT_PERIODS);
      gone = '0;
      for (i = 0; i < nb_cnt; i++)
         if (nb_sil[i] != dvrt_pkg::SIL_MAX) nb_sil[i]++;
      i = 0;
      while (i < nb_cnt) begin
         if (nb_sil[i] > lim) begin
            drop_neighbor_at(i);
            if (gone != dvrt_pkg::GONE_MAX) gone++;
         end else begin
            i++;
         end
      end
      return gone;
   endfunction

   // Work out the result an accepted item must produce and queue it.
   function automatic void predict_result(route_req_type r);
      route_rsp_type e;
      int idx;
      logic found;
      e = '{dvrt_pkg::STS_MISS, '0, '0, '0};
      case (r.op)
         dvrt_pkg::OP_ADD: e.status = nb_adopt(r.nbr, r.metric);
         dvrt_pkg::OP_DEL: begin
            idx = nb_position(r.nbr);
            if (idx >= 0) begin
               drop_neighbor_at(idx);
               e.status = dvrt_pkg::STS_DONE;
            end
         end
         dvrt_pkg::OP_UPDATE: e.status = apply_update(r);
         dvrt_pkg::OP_LOOKUP: begin
            // Strict less-than keeps the lowest index on equal cost.
            found = 1'b0;
            for (int i = 0; i < rt_cnt; i++)
               if (rt_dest[i] == r.dest && (!found || rt_cost[i] < e.cost)) begin
                  found = 1'b1;
                  e.cost = rt_cost[i];
                  e.hop = rt_via[i];
               end
            e.status = found ? dvrt_pkg::STS_DONE : dvrt_pkg::STS_MISS;
         end
         dvrt_pkg::OP_TICK: begin
            e.gone = age_neighbors();
            e.status = dvrt_pkg::STS_DONE;
         end
         default: ;
      endcase
      if (e.gone != 0) timeouts_seen++;
      if (e.status == dvrt_pkg::STS_FULL) full_seen++;
      owed_rsps.push_back(e);
   endfunction

   // Clock and cycle guard.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, owed_rsps.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Driver: predict on acceptance, hold an offered item until taken, else idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_result(pending_reqs.pop_front());
            items_sent++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold the current item
         end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid         <= 1'b1;
            req_chan.op            <= pending_reqs[0].op;
            req_chan.neighbor_addr <= pending_reqs[0].nbr;
            req_chan.dest_addr     <= pending_reqs[0].dest;
            req_chan.metric        <= pending_reqs[0].metric;
            req_chan.link_cost     <= pending_reqs[0].link;
            req_chan.last_entry    <= pending_reqs[0].last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each result with the oldest owed one; stall ready at random.
   always @(posedge clock) begin
      route_rsp_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_rsps.size() == 0) begin
               $error("unexpected result: status %0d next_hop %h", rsp_chan.status,
                      rsp_chan.next_hop);
               fail_count++;
            end else begin
               e = owed_rsps.pop_front();
               rsps_checked++;
               if (rsp_chan.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_chan.status);
                  fail_count++;
               end
               if (rsp_chan.next_hop !== e.hop) begin
                  $error("next_hop: expected %h, got %h", e.hop, rsp_chan.next_hop);
                  fail_count++;
               end
               if (rsp_chan.route_cost !== e.cost) begin
                  $error("route_cost: expected %0d, got %0d", e.cost, rsp_chan.route_cost);
                  fail_count++;
               end
               if (rsp_chan.timed_out !== e.gone) begin
                  $error("timed_out: expected %0d, got %0d", e.gone, rsp_chan.timed_out);
                  fail_count++;
               end
            end
         end
         // Long hold-off: keep ready low for many cycles so the block backs up.
         if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= 300;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [dvrt_pkg::COST_W-1:0] pick_cost();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return dvrt_pkg::COST_W'($urandom);
      endcase
   endfunction

   function automatic logic [dvrt_pkg::COST_W-1:0] rnd_cost();
      return dvrt_pkg::COST_W'($urandom);
   endfunction

   function automatic logic rnd_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [dvrt_pkg::ADDR_W-1:0] pick_addr();
      return addr_pool[$urandom_range(15)];
   endfunction

   task automatic push_req(logic [dvrt_pkg::OP_W-1:0] op, logic [dvrt_pkg::ADDR_W-1:0] n,
                           logic [dvrt_pkg::ADDR_W-1:0] d, logic [dvrt_pkg::COST_W-1:0] m,
                           logic [dvrt_pkg::COST_W-1:0] l, logic last);
      route_req_type r;
      r = '{op, n, d, m, l, last};
      pending_reqs.push_back(r);
   endtask

   // Wait until everything is sent and answered, then let the block settle.
   task automatic drain();
      while (pending_reqs.size() > 0 || owed_rsps.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(dvrt_pkg::csr_index_type idx, logic [dvrt_pkg::CSR_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == dvrt_pkg::CSR_OWN_ADDRESS) own_addr = v;
      else period = v[dvrt_pkg::PERIOD_W-1:0];
      @(posedge clock);
   endtask

   // Refresh the address pool; keep own address and both extremes in it.
   task automatic fill_pool();
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      addr_pool[0] = own_addr;
      addr_pool[1] = '0;
      addr_pool[2] = '1;
   endtask

   // One random burst: mostly well-formed update messages, plus table maintenance and noise.
   task automatic random_burst(int count);
      int k, n, sel;
      logic [dvrt_pkg::ADDR_W-1:0] sender;
      logic [dvrt_pkg::COST_W-1:0] link;
      k = 0;
      while (k < count) begin
         sel = $urandom_range(99);
         if (sel < 14) begin
            push_req(dvrt_pkg::OP_ADD, pick_addr(), $urandom, pick_cost(), rnd_cost(),
                     rnd_bit());
            k++;
         end else if (sel < 22) begin
            push_req(dvrt_pkg::OP_DEL, pick_addr(), $urandom, rnd_cost(), rnd_cost(),
                     rnd_bit());
            k++;
         end else if (sel < 62) begin
            // An update message of a few entries from one sender.
            sender = pick_addr();
            link = pick_cost();
            n = $urandom_range(1, 6);
            for (int j = 0; j < n; j++)
               push_req(dvrt_pkg::OP_UPDATE, sender,
                        ($urandom_range(9) == 0) ? sender : pick_addr(),
                        pick_cost(), link, (j == n - 1) && ($urandom_range(9) != 0));
            k += n;
         end else if (sel < 67) begin
            // Lone or broken entries.
            push_req(dvrt_pkg::OP_UPDATE, pick_addr(), pick_addr(), pick_cost(), pick_cost(),
                     rnd_bit());
            k++;
         end else if (sel < 86) begin
            push_req(dvrt_pkg::OP_LOOKUP, $urandom, pick_addr(), rnd_cost(), rnd_cost(),
                     rnd_bit());
            k++;
         end else if (sel < 97) begin
            push_req(dvrt_pkg::OP_TICK, $urandom, $urandom, rnd_cost(), rnd_cost(),
                     rnd_bit());
            k++;
         end else begin
            push_req(dvrt_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom,
                     $urandom, rnd_cost(), rnd_cost(), rnd_bit());
            k++;
         end
      end
   endtask

   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
         default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
   endtask

   // Sequencer.
   initial begin
      logic [dvrt_pkg::ADDR_W-1:0] a1, a2, a3;
      req_chan.valid = 1'b0;
      req_chan.op = dvrt_pkg::OP_ADD;
      req_chan.neighbor_addr = '0;
      req_chan.dest_addr = '0;
      req_chan.metric = '0;
      req_chan.link_cost = '0;
      req_chan.last_entry = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = dvrt_pkg::CSR_OWN_ADDRESS;
      csr_write_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = 0;
      hold_seen = 0;
      hold_left = 0;
      fail_count = 0;
      items_sent = 0;
      rsps_checked = 0;
      timeouts_seen = 0;
      full_seen = 0;
      nb_cnt = 0;
      rt_cnt = 0;
      msg_seq = '0;
      own_addr = '0;
      period = 16'd5;
      foreach (nb_addr[i]) begin
         nb_addr[i] = '0; nb_wt[i] = '0; nb_sil[i] = '0;
      end
      foreach (rt_dest[i]) begin
         rt_dest[i] = '0; rt_via[i] = '0; rt_cost[i] = '0; rt_stamp[i] = '0;
      end
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, default registers: own address zero, period five.
      a1 = 32'h0A00_0001;
      a2 = 32'h0A00_0002;
      a3 = 32'hFFFF_FFFF;
      push_req(dvrt_pkg::OP_ADD, 32'h0, 32'h0, 16'd1, 16'd0, 1'b0);     // own address: reject
      push_req(dvrt_pkg::OP_ADD, a1, 32'h0, 16'd10, 16'd0, 1'b0);
      push_req(dvrt_pkg::OP_ADD, a1, 32'h0, 16'd3, 16'd0, 1'b0);        // duplicate: reject
      push_req(dvrt_pkg::OP_ADD, a3, 32'h0, 16'hFFFF, 16'd0, 1'b0);
      push_req(dvrt_pkg::OP_DEL, a2, 32'h0, 16'd0, 16'd0, 1'b0);        // unknown: reject
      push_req(dvrt_pkg::OP_UPDATE, a1, 32'h0B00_0000, 16'hFFFF, 16'd0, 1'b0); // saturates
      push_req(dvrt_pkg::OP_UPDATE, a2, 32'h0B00_0000, 16'd5, 16'd7, 1'b0);   // adopted
      push_req(dvrt_pkg::OP_UPDATE, a2, a2, 16'd1, 16'd7, 1'b1);        // names itself, purges
      push_req(dvrt_pkg::OP_LOOKUP, 32'h0, 32'h0B00_0000, 16'd0, 16'd0, 1'b0);
      push_req(dvrt_pkg::OP_LOOKUP, 32'h0, 32'h0C00_0000, 16'd0, 16'd0, 1'b0); // miss
      push_req(dvrt_pkg::OP_UPDATE, a1, 32'h0C00_0000, 16'd2, 16'd0, 1'b1);  // stale via a1
      push_req(dvrt_pkg::OP_LOOKUP, 32'h0, 32'h0B00_0000, 16'd0, 16'd0, 1'b0);
      push_req(dvrt_pkg::OP_UPDATE, a3, 32'h0C00_0000, 16'd11, 16'd0, 1'b1); // saturates
      push_req(dvrt_pkg::OP_LOOKUP, 32'h0, 32'h0C00_0000, 16'd0, 16'd0, 1'b0);
      push_req(OP_UNUSED_LO, a1, a1, 16'd1, 16'd1, 1'b1);
      push_req(OP_UNUSED_MID, a1, a1, 16'd1, 16'd1, 1'b0);
      push_req(OP_UNUSED_HI, a1, a1, 16'd1, 16'd1, 1'b1);
      for (int i = 0; i < 7; i++)                                       // fill, then overflow
         push_req(dvrt_pkg::OP_ADD, 32'h0D00_0000 + 32'(i), 32'h0, 16'd1, 16'd0, 1'b0);
      push_req(dvrt_pkg::OP_DEL, a1, 32'h0, 16'd0, 16'd0, 1'b0);
      drain();

      // Phases: registers at several settings including extremes, idling rotated.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(dvrt_pkg::CSR_OWN_ADDRESS, $urandom);
               write_csr(dvrt_pkg::CSR_UPDATE_PERIOD, 32'd1);
            end
            1: begin
               write_csr(dvrt_pkg::CSR_OWN_ADDRESS, '1);
               write_csr(dvrt_pkg::CSR_UPDATE_PERIOD, 32'h0000_FFFF);
            end
            2: begin
               write_csr(dvrt_pkg::CSR_OWN_ADDRESS, '0);
               write_csr(dvrt_pkg::CSR_UPDATE_PERIOD, 32'd2);
            end
            3: begin write_csr(dvrt_pkg::CSR_UPDATE_PERIOD, 32'd1); end
            4: begin
               write_csr(dvrt_pkg::CSR_OWN_ADDRESS, $urandom);
               write_csr(dvrt_pkg::CSR_UPDATE_PERIOD, 32'd3);
            end
            default: begin
               write_csr(dvrt_pkg::CSR_UPDATE_PERIOD, $urandom_range(1, 4));
            end
         endcase
         fill_pool();
         set_idling(phase);
         random_burst(130);
         if (phase == 2) begin
            // Stop answering for a long stretch while items keep coming.
            hold_requests++;
         end
         if (phase == 3) begin
            // Let the sender pause until every owed result has come back.
            while (pending_reqs.size() > 0 || owed_rsps.size() > 0) @(posedge clock);
         end
         random_burst(130);
         drain();
      end

      $display("covered %0d items, %0d results checked", items_sent, rsps_checked);
      $display("ticks with timeouts: %0d, full-table overwrites: %0d", timeouts_seen, full_seen);
      if (fail_count == 0 && owed_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/dvrt_pkg.sv
sv/dvrt_if.sv
sv/dvrt_route_engine.sv
sv/distance_vector_route_table_unit.sv
sim/distance_vector_route_table_unit_test.sv
